>>> rtl/dnsdc_pkg.sv
`timescale 1ns / 1ps

package dnsdc_pkg;

  // Packet store and name buffer sizing
  localparam int PacketBytes = 2048;
  localparam int NameLimit   = 255;
  localparam int NameBuf     = 256;
  localparam int NameCap     = (NameLimit < NameBuf) ? NameLimit : NameBuf;

  localparam int AddrW  = $clog2(PacketBytes);
  localparam int LenW   = $clog2(PacketBytes + 1);
  localparam int PosW   = ((LenW + 1) > 14) ? (LenW + 1) : 14;
  localparam int NameW  = $clog2(NameCap + 1);

  localparam int ChunkBytes = 8;
  localparam int MaxChunks  = (NameCap + ChunkBytes - 1) / ChunkBytes;
  localparam int ChunkW     = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;

  // Fixed field widths of the channels
  localparam int OffsetW    = 11;
  localparam int ChunkDataW = 64;
  localparam int CountW     = 4;
  localparam int ReasonW    = 3;
  localparam int JumpW      = 4;

  localparam logic [JumpW-1:0] JumpLimitReset = 4'd5;
  localparam logic [7:0]       PtrMark        = 8'hC0;
  localparam logic [7:0]       PtrHighMask    = 8'h3F;
  localparam logic [7:0]       DotChar        = 8'h2E;

  typedef enum logic [ReasonW-1:0] {
    REASON_ZERO    = 3'd0,
    REASON_END     = 3'd1,
    REASON_JUMPS   = 3'd2,
    REASON_OVERRUN = 3'd3,
    REASON_TRUNC   = 3'd4
  } end_reason_e;

  // One name character handed to the chunk buffer
  typedef struct packed {
    logic             vld;
    logic [NameW-1:0] idx;
    logic [7:0]       data;
  } app_t;

  // Walk finished: final name length and why it stopped
  typedef struct packed {
    logic             vld;
    logic [NameW-1:0] n;
    end_reason_e      reason;
  } fin_t;

endpackage

>>> rtl/dnsdc_if.sv
`timescale 1ns / 1ps

interface dnsdc_in_if import dnsdc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         data_byte;
  logic               first_byte;
  logic [OffsetW-1:0] start_offset;

  modport source (output valid, kind, data_byte, first_byte, start_offset, input ready);
  modport sink   (input valid, kind, data_byte, first_byte, start_offset, output ready);
endinterface

interface dnsdc_out_if import dnsdc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [ChunkDataW-1:0] name_chunk;
  logic [CountW-1:0]     chunk_count;
  logic                  last;
  logic [ReasonW-1:0]    end_reason;

  modport source (output valid, name_chunk, chunk_count, last, end_reason, input ready);
  modport sink   (input valid, name_chunk, chunk_count, last, end_reason, output ready);
endinterface

interface dnsdc_cfg_if import dnsdc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [JumpW-1:0] jump_limit;

  modport source (output valid, jump_limit, input ready);
  modport sink   (input valid, jump_limit, output ready);
endinterface

>>> rtl/dns_name_decompress_core.sv
`timescale 1ns / 1ps

// DNS name decoder with compression pointer support. Items with kind 0 load
// one packet byte each; first_byte restarts the packet at address zero, and
// bytes beyond the store size are dropped. Items with kind 1 walk the name
// from start_offset through a packet store with one write port and one
// registered read port. Each walk step tests the position and reads the
// length byte; a pointer step then reads its low byte, and a label emits a
// dot after the first label, primes the read and then reads its characters.
// The name is gathered into a chunk buffer and then sent as items of up to
// eight characters, each read, loaded into the output register and held
// until taken, all chunks carrying the end reason. The input is not ready
// from the parse item until its last chunk is taken. jump_limit (reset 5)
// is written through the configuration channel; the user must write it only
// while the block is idle, and the block itself does not enforce this. The
// packet store holds no reset value; the walk never uses a byte read above the length.
module dns_name_decompress_core import dnsdc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  dnsdc_in_if.sink    in_if,
  dnsdc_out_if.source out_if,
  dnsdc_cfg_if.sink   cfg_if
);

  typedef enum logic [2:0] {
    W_IDLE, W_CHECK, W_LEN, W_PTR, W_DOT, W_RD, W_CHAR, W_DONE
  } walk_state_e;

  walk_state_e      state_q;
  logic [LenW-1:0]  pkt_len_q;
  logic [JumpW-1:0] jump_limit_q;
  logic [JumpW-1:0] jumps_q;
  logic [PosW-1:0]  pos_q;
  logic [7:0]       lab_cnt_q;
  logic [NameW-1:0] n_q;
  logic [5:0]       ptr_hi_q;
  app_t             app_q;
  app_t             app_d;
  fin_t             fin_q;
  fin_t             fin_d;

  logic [7:0]       store_mem [PacketBytes];
  logic [7:0]       st_rdata_q;
  logic [AddrW-1:0] st_raddr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;

  logic             in_acc;
  logic             chunk_busy;
  logic [PosW-1:0]  pos_inc;
  logic [PosW-1:0]  len_ext;
  logic [PosW-1:0]  lab_end;
  logic [7:0]       ptr_masked;
  logic             is_ptr;
  logic             name_full;

  assign in_if.ready  = (state_q == W_IDLE) && !chunk_busy;
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;

  assign pos_inc    = pos_q + 1'b1;
  assign len_ext    = PosW'(pkt_len_q);
  assign lab_end    = pos_inc + PosW'(st_rdata_q);
  assign ptr_masked = st_rdata_q & PtrHighMask;
  assign is_ptr     = ((st_rdata_q & PtrMark) == PtrMark);
  assign name_full  = (n_q >= NameW'(NameCap));

  // Load path: a first byte goes to address zero, others append until full
  assign wr_en   = in_acc && !in_if.kind &&
                   (in_if.first_byte || (pkt_len_q < LenW'(PacketBytes)));
  assign wr_addr = in_if.first_byte ? '0 : pkt_len_q[AddrW-1:0];

  // Read ahead by one where the next byte is already known
  always_comb begin
    case (state_q)
      W_LEN, W_CHAR: st_raddr = pos_inc[AddrW-1:0];
      default:       st_raddr = pos_q[AddrW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= in_if.data_byte;
    end
    st_rdata_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_limit_q <= JumpLimitReset;
    end else if (cfg_if.valid && cfg_if.ready) begin
      jump_limit_q <= cfg_if.jump_limit;
    end
  end

  // Append a dot or a character while the name has room
  always_comb begin
    app_d = '{vld: 1'b0, idx: n_q, data: DotChar};
    case (state_q)
      W_DOT: begin
        app_d.vld = !name_full;
      end
      W_CHAR: begin
        app_d.vld  = !name_full;
        app_d.data = st_rdata_q;
      end
      default: begin
      end
    endcase
  end

  // End of walk and its reason
  always_comb begin
    fin_d = '{vld: 1'b0, n: n_q, reason: REASON_ZERO};
    case (state_q)
      W_CHECK: begin
        // Packet end takes precedence over the jump limit
        if (pos_q >= len_ext) begin
          fin_d.vld    = 1'b1;
          fin_d.reason = REASON_END;
        end else if (jumps_q >= jump_limit_q) begin
          fin_d.vld    = 1'b1;
          fin_d.reason = REASON_JUMPS;
        end
      end
      W_LEN: begin
        if (st_rdata_q == 8'd0) begin
          fin_d.vld    = 1'b1;
          fin_d.reason = REASON_ZERO;
        end else if (is_ptr) begin
          // Pointer whose low byte lies past the end stops the walk
          if (pos_inc >= len_ext) begin
            fin_d.vld    = 1'b1;
            fin_d.reason = REASON_END;
          end
        end else if (lab_end > len_ext) begin
          fin_d.vld    = 1'b1;
          fin_d.reason = REASON_OVERRUN;
        end
      end
      W_DOT, W_CHAR: begin
        if (name_full) begin
          fin_d.vld    = 1'b1;
          fin_d.reason = REASON_TRUNC;
        end
      end
      default: begin
      end
    endcase
  end

  // Walk sequencer: one length byte, pointer byte or character per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= W_IDLE;
      pkt_len_q <= '0;
      jumps_q   <= '0;
      pos_q     <= '0;
      lab_cnt_q <= '0;
      n_q       <= '0;
      ptr_hi_q  <= '0;
      app_q     <= '0;
      fin_q     <= '{vld: 1'b0, n: '0, reason: REASON_ZERO};
    end else begin
      app_q <= app_d;
      fin_q <= fin_d;
      if (fin_d.vld) begin
        state_q <= W_DONE;
      end else begin
        case (state_q)
          W_IDLE: begin
            if (in_acc) begin
              if (!in_if.kind) begin
                if (in_if.first_byte) begin
                  pkt_len_q <= LenW'(1);
                end else if (pkt_len_q < LenW'(PacketBytes)) begin
                  pkt_len_q <= pkt_len_q + 1'b1;
                end
              end else begin
                pos_q   <= PosW'(in_if.start_offset);
                jumps_q <= '0;
                n_q     <= '0;
                state_q <= W_CHECK;
              end
            end
          end
          W_CHECK: begin
            state_q <= W_LEN;
          end
          W_LEN: begin
            if (is_ptr) begin
              ptr_hi_q <= ptr_masked[5:0];
              state_q  <= W_PTR;
            end else begin
              pos_q     <= pos_inc;
              lab_cnt_q <= st_rdata_q;
              state_q   <= (n_q != '0) ? W_DOT : W_RD;
            end
          end
          W_PTR: begin
            pos_q   <= PosW'({ptr_hi_q, st_rdata_q});
            jumps_q <= jumps_q + 1'b1;
            state_q <= W_CHECK;
          end
          W_DOT: begin
            n_q     <= n_q + 1'b1;
            state_q <= W_RD;
          end
          W_RD: begin
            state_q <= W_CHAR;
          end
          W_CHAR: begin
            n_q       <= n_q + 1'b1;
            pos_q     <= pos_inc;
            lab_cnt_q <= lab_cnt_q - 1'b1;
            if (lab_cnt_q == 8'd1) begin
              state_q <= W_CHECK;
            end
          end
          W_DONE: begin
            // Hand over to the chunk buffer; ready stays low while it sends
            state_q <= W_IDLE;
          end
          default: begin
            state_q <= W_IDLE;
          end
        endcase
      end
    end
  end

  dnsdc_chunk u_chunk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .app_i  (app_q),
    .fin_i  (fin_q),
    .busy_o (chunk_busy),
    .out_if (out_if)
  );

endmodule

>>> rtl/dnsdc_chunk.sv
`timescale 1ns / 1ps

module dnsdc_chunk import dnsdc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  app_t  app_i,
  input  fin_t  fin_i,
  output logic  busy_o,
  dnsdc_out_if.source out_if
);

  typedef enum logic [1:0] {E_IDLE, E_FETCH, E_LOAD, E_SEND} emit_state_e;

  emit_state_e           state_q;
  logic [ChunkDataW-1:0] asm_q;
  logic [ChunkDataW-1:0] asm_ins;
  logic [ChunkDataW-1:0] word_mem [MaxChunks];
  logic [ChunkDataW-1:0] rd_q;
  logic                  we;
  logic [ChunkW-1:0]     waddr;
  logic [ChunkDataW-1:0] wdata;
  logic [2:0]            lane;
  logic [ChunkW-1:0]     k_q;
  logic [NameW-1:0]      rem_q;
  end_reason_e           reason_q;
  logic                  last_c;
  logic [CountW-1:0]     count_c;

  logic                  valid_q;
  logic [ChunkDataW-1:0] chunk_q;
  logic [CountW-1:0]     count_q;
  logic                  last_q;
  end_reason_e           out_reason_q;

  assign lane = app_i.idx[2:0];

  always_comb begin
    asm_ins = asm_q;
    asm_ins[lane*8 +: 8] = app_i.data;
  end

  // Store a word once its last lane fills, and the partial or empty word at the end
  always_comb begin
    we    = 1'b0;
    waddr = ChunkW'(app_i.idx >> 3);
    wdata = asm_ins;
    if (app_i.vld && (lane == 3'd7)) begin
      we = 1'b1;
    end else if (fin_i.vld && ((fin_i.n[2:0] != 3'd0) || (fin_i.n == '0))) begin
      we    = 1'b1;
      waddr = ChunkW'(fin_i.n >> 3);
      wdata = asm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      word_mem[waddr] <= wdata;
    end
    rd_q <= word_mem[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q <= '0;
    end else if (app_i.vld) begin
      asm_q <= (lane == 3'd7) ? '0 : asm_ins;
    end else if (fin_i.vld) begin
      asm_q <= '0;
    end
  end

  assign last_c  = (rem_q <= NameW'(ChunkBytes));
  assign count_c = last_c ? rem_q[CountW-1:0] : CountW'(ChunkBytes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= E_IDLE;
      k_q          <= '0;
      rem_q        <= '0;
      reason_q     <= REASON_ZERO;
      valid_q      <= 1'b0;
      chunk_q      <= '0;
      count_q      <= '0;
      last_q       <= 1'b0;
      out_reason_q <= REASON_ZERO;
    end else begin
      case (state_q)
        E_IDLE: begin
          if (fin_i.vld) begin
            k_q      <= '0;
            rem_q    <= fin_i.n;
            reason_q <= fin_i.reason;
            state_q  <= E_FETCH;
          end
        end
        E_FETCH: begin
          state_q <= E_LOAD;
        end
        E_LOAD: begin
          chunk_q      <= rd_q;
          count_q      <= count_c;
          last_q       <= last_c;
          out_reason_q <= reason_q;
          valid_q      <= 1'b1;
          state_q      <= E_SEND;
        end
        E_SEND: begin
          if (out_if.ready) begin
            valid_q <= 1'b0;
            if (last_q) begin
              state_q <= E_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              rem_q   <= rem_q - NameW'(ChunkBytes);
              state_q <= E_FETCH;
            end
          end
        end
        default: begin
          state_q <= E_IDLE;
        end
      endcase
    end
  end

  assign busy_o             = (state_q != E_IDLE);
  assign out_if.valid       = valid_q;
  assign out_if.name_chunk  = chunk_q;
  assign out_if.chunk_count = count_q;
  assign out_if.last        = last_q;
  assign out_if.end_reason  = out_reason_q;

endmodule

>>> rtl/dnsdc_core_chk.sv
`timescale 1ns / 1ps

module dnsdc_core_chk import dnsdc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_last,
  input logic [CountW-1:0] out_count
);

  // Hold a pending chunk until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("chunk dropped before it was taken");

  // Only the final chunk of a name may be short
  a_full_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_last) |-> (out_count == CountW'(ChunkBytes)))
    else $error("short chunk before the last one");

  // No new item while a chunk is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input ready while a chunk is pending");

  // A load item produces no chunk
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && !in_kind) |=> !out_valid)
    else $error("chunk after a load item");

  // Nothing follows the final chunk at once
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("chunk straight after the last one");

endmodule

bind dns_name_decompress_core dnsdc_core_chk u_core_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_kind   (in_if.kind),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_last  (out_if.last),
  .out_count (out_if.chunk_count)
);
